[src/rctc_pkg.sv]
// ----------------------------------------------------------------------------
// rctc_pkg - shared types, constants and microcode for the throttle curve ramp
// Holds field widths, register indexes, the S-curve tables, the control word
// layout and the read-only program that drives the datapath.
// ----------------------------------------------------------------------------
package rctc_pkg;

  // Field widths
  localparam int PW_W   = 15;  // pulse widths and pulse limits
  localparam int CV_W   = 11;  // signed throttle settings
  localparam int DB_W   = 10;  // deadband
  localparam int SPD_W  = 8;   // speeds and ramp step
  localparam int THR_W  = 16;  // mapped throttle

  // Divider widths: |num| <= 32767 * 2047 < 2^27, |den| <= 32767
  localparam int NUM_W  = 27;
  localparam int NUMS_W = NUM_W + 1;
  localparam int DEN_W  = 15;
  localparam int DENS_W = DEN_W + 1;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int SUM_W  = NUMS_W + 1;

  localparam int THR_MAX = 32767;
  localparam int THR_MIN = -32768;

  // S-curve
  localparam int CURVE_POINTS = 12;
  localparam int K_W = $clog2(CURVE_POINTS);
  localparam logic [SPD_W-1:0] CURVE_IN [CURVE_POINTS] =
    '{8'd0, 8'd48, 8'd69, 8'd88, 8'd97, 8'd118, 8'd135, 8'd154, 8'd174, 8'd202, 8'd222,
      8'd255};
  localparam logic [SPD_W-1:0] CURVE_OUT [CURVE_POINTS] =
    '{8'd0, 8'd23, 8'd46, 8'd69, 8'd92, 8'd115, 8'd138, 8'd161, 8'd184, 8'd207, 8'd230,
      8'd255};

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN          = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX          = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENT_THRESHOLD = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_VALUE       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND         = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP        = 4'd7;

  typedef struct packed {
    logic [PW_W-1:0]        pulse_low;
    logic [PW_W-1:0]        pulse_high;
    logic signed [CV_W-1:0] out_min;
    logic signed [CV_W-1:0] out_max;
    logic [PW_W-1:0]        absent_threshold;
    logic signed [CV_W-1:0] idle_value;
    logic [DB_W-1:0]        deadband;
    logic [SPD_W-1:0]       ramp_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_low:        15'd875,
    pulse_high:       15'd2140,
    out_min:          -11'sd255,
    out_max:          11'sd255,
    absent_threshold: 15'd100,
    idle_value:       11'sd0,
    deadband:         10'd10,
    ramp_step:        8'd15
  };

  // Microcode
  localparam int PC_W   = 4;
  localparam int OP_W   = 4;
  localparam int COND_W = 4;

  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_FETCH     = 4'd1;
  localparam logic [OP_W-1:0] OP_MAP       = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_START = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd4;
  localparam logic [OP_W-1:0] OP_MAP_END   = 4'd5;
  localparam logic [OP_W-1:0] OP_CLAMP     = 4'd6;
  localparam logic [OP_W-1:0] OP_SEARCH    = 4'd7;
  localparam logic [OP_W-1:0] OP_SEG       = 4'd8;
  localparam logic [OP_W-1:0] OP_CURVE_END = 4'd9;
  localparam logic [OP_W-1:0] OP_RAMP      = 4'd10;

  localparam logic [COND_W-1:0] C_NEXT     = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NO_REQ   = 4'd2;
  localparam logic [COND_W-1:0] C_BYPASS   = 4'd3;
  localparam logic [COND_W-1:0] C_DIV_MORE = 4'd4;
  localparam logic [COND_W-1:0] C_CLAMP    = 4'd5;
  localparam logic [COND_W-1:0] C_SEARCH   = 4'd6;
  localparam logic [COND_W-1:0] C_SEG_DONE = 4'd7;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd8;

  localparam logic [PC_W-1:0] STEP_FETCH     = 4'd0;
  localparam logic [PC_W-1:0] STEP_MAP       = 4'd1;
  localparam logic [PC_W-1:0] STEP_MAP_DIVS  = 4'd2;
  localparam logic [PC_W-1:0] STEP_MAP_DIVL  = 4'd3;
  localparam logic [PC_W-1:0] STEP_MAP_END   = 4'd4;
  localparam logic [PC_W-1:0] STEP_CLAMP     = 4'd5;
  localparam logic [PC_W-1:0] STEP_SEARCH    = 4'd6;
  localparam logic [PC_W-1:0] STEP_SEG       = 4'd7;
  localparam logic [PC_W-1:0] STEP_SEG_DIVS  = 4'd8;
  localparam logic [PC_W-1:0] STEP_SEG_DIVL  = 4'd9;
  localparam logic [PC_W-1:0] STEP_CURVE_END = 4'd10;
  localparam logic [PC_W-1:0] STEP_RAMP      = 4'd11;
  localparam logic [PC_W-1:0] STEP_WRAP      = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic req_taken;
    logic bypass;
    logic div_more;
    logic clamp;
    logic search_more;
    logic seg_done;
    logic out_busy;
  } stat_t;

  // One control word per step; a taken condition jumps to target, else advance
  function automatic ctrl_t ctrl_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_FETCH:     w = '{op: OP_FETCH,     cond: C_NO_REQ,   target: STEP_FETCH};
      STEP_MAP:       w = '{op: OP_MAP,       cond: C_BYPASS,   target: STEP_CLAMP};
      STEP_MAP_DIVS:  w = '{op: OP_DIV_START, cond: C_NEXT,     target: STEP_FETCH};
      STEP_MAP_DIVL:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: STEP_MAP_DIVL};
      STEP_MAP_END:   w = '{op: OP_MAP_END,   cond: C_NEXT,     target: STEP_FETCH};
      STEP_CLAMP:     w = '{op: OP_CLAMP,     cond: C_CLAMP,    target: STEP_RAMP};
      STEP_SEARCH:    w = '{op: OP_SEARCH,    cond: C_SEARCH,   target: STEP_SEARCH};
      STEP_SEG:       w = '{op: OP_SEG,       cond: C_SEG_DONE, target: STEP_RAMP};
      STEP_SEG_DIVS:  w = '{op: OP_DIV_START, cond: C_NEXT,     target: STEP_FETCH};
      STEP_SEG_DIVL:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: STEP_SEG_DIVL};
      STEP_CURVE_END: w = '{op: OP_CURVE_END, cond: C_NEXT,     target: STEP_FETCH};
      STEP_RAMP:      w = '{op: OP_RAMP,      cond: C_OUT_BUSY, target: STEP_RAMP};
      STEP_WRAP:      w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_FETCH};
      default:        w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

[src/rctc_div.sv]
// ----------------------------------------------------------------------------
// rctc_div - restoring divider, one quotient bit per step
// Unsigned magnitudes in, unsigned quotient out; the caller handles signs.
// ----------------------------------------------------------------------------
module rctc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        step,
  input  logic [rctc_pkg::NUM_W-1:0]  num_mag,
  input  logic [rctc_pkg::DEN_W-1:0]  den_mag,
  output logic [rctc_pkg::NUM_W-1:0]  quo,
  output logic                        more
);
  import rctc_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign more    = cnt != CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= den_mag;
      quo <= num_mag;
    end else if (step) begin
      if (fits) begin
        rem <= DEN_W'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

[src/rctc_seq.sv]
// ----------------------------------------------------------------------------
// rctc_seq - step counter and control store
// Fetches one control word per step and resolves its conditional jump.
// ----------------------------------------------------------------------------
module rctc_seq (
  input  logic            clk,
  input  logic            rst,
  input  rctc_pkg::stat_t stat,
  output rctc_pkg::ctrl_t ctrl
);
  import rctc_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  assign ctrl = ctrl_rom(pc);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_REQ:   jump = ~stat.req_taken;
      C_BYPASS:   jump = stat.bypass;
      C_DIV_MORE: jump = stat.div_more;
      C_CLAMP:    jump = stat.clamp;
      C_SEARCH:   jump = stat.search_more;
      C_SEG_DONE: jump = stat.seg_done;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[src/rctc_datapath.sv]
// ----------------------------------------------------------------------------
// rctc_datapath - map, curve and ramp datapath
// Executes the operation of the current control word and reports flags.
// ----------------------------------------------------------------------------
module rctc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rctc_pkg::ctrl_t                   ctrl,
  input  rctc_pkg::cfg_t                    cfg,
  output rctc_pkg::stat_t                   stat,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rctc_pkg::PW_W-1:0]         pulse_width,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rctc_pkg::THR_W-1:0] throttle,
  output logic [rctc_pkg::SPD_W-1:0]        goal_speed,
  output logic [rctc_pkg::SPD_W-1:0]        speed,
  output logic                              signal_absent
);
  import rctc_pkg::*;

  // Working registers
  logic [PW_W-1:0]          p;
  logic                     absent;
  logic signed [NUMS_W-1:0] num;
  logic signed [DENS_W-1:0] den;
  logic                     q_neg;
  logic signed [THR_W-1:0]  thr;
  logic [K_W-1:0]           k;
  logic [SPD_W-1:0]         goal;
  logic [SPD_W-1:0]         last_speed;

  // Divider hookup
  logic                     div_start;
  logic                     div_step;
  logic [NUM_W-1:0]         num_mag;
  logic [DEN_W-1:0]         den_mag;
  logic [NUM_W-1:0]         quo;
  logic                     div_more;
  logic signed [NUMS_W-1:0] q_s;

  // Map terms
  logic                     absent_now;
  logic                     bypass;
  logic signed [DENS_W-1:0] p_off;
  logic signed [CV_W:0]     out_span;
  logic signed [NUMS_W-1:0] map_prod;
  logic signed [DENS_W-1:0] den_map;
  logic signed [SUM_W-1:0]  map_sum;
  logic signed [THR_W-1:0]  sat;
  logic signed [THR_W:0]    sat_x;
  logic signed [THR_W:0]    db_s;
  logic signed [THR_W-1:0]  thr_map;

  // Curve terms
  logic signed [THR_W-1:0]  in_k;
  logic signed [THR_W-1:0]  in_km1;
  logic signed [THR_W-1:0]  in_first;
  logic signed [THR_W-1:0]  in_last;
  logic signed [SPD_W:0]    seg_dy;
  logic signed [THR_W-1:0]  seg_dv;
  logic signed [THR_W-1:0]  seg_span;
  logic signed [NUMS_W-1:0] seg_prod;
  logic signed [NUMS_W-1:0] curve_sum;

  // Ramp terms
  logic [SPD_W:0]           step_sum;
  logic                     rise;
  logic [SPD_W-1:0]         spd;

  assign in_ready = ctrl.op == OP_FETCH;

  // ---- map ----
  assign absent_now = p < cfg.absent_threshold;

  assign bypass   = absent_now || (cfg.pulse_high == cfg.pulse_low);
  assign p_off    = $signed({1'b0, p}) - $signed({1'b0, cfg.pulse_low});
  assign out_span = $signed({cfg.out_max[CV_W-1], cfg.out_max})
                  - $signed({cfg.out_min[CV_W-1], cfg.out_min});
  assign map_prod = NUMS_W'(p_off) * NUMS_W'(out_span);
  assign den_map  = $signed({1'b0, cfg.pulse_high}) - $signed({1'b0, cfg.pulse_low});

  assign num_mag = num[NUMS_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_mag = den[DENS_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign q_s     = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign map_sum = SUM_W'(q_s) + SUM_W'(cfg.out_min);

  always_comb begin
    if (map_sum > $signed(SUM_W'(THR_MAX))) begin
      sat = THR_W'(THR_MAX);
    end else if (map_sum < $signed(SUM_W'(THR_MIN))) begin
      sat = THR_W'(THR_MIN);
    end else begin
      sat = map_sum[THR_W-1:0];
    end
    sat_x = (THR_W+1)'(sat);
    db_s  = $signed({{(THR_W+1-DB_W){1'b0}}, cfg.deadband});
    if (sat_x < db_s && sat_x > -db_s) begin
      thr_map = '0;
    end else begin
      thr_map = sat;
    end
  end

  // ---- curve ----
  assign in_k     = $signed({{(THR_W-SPD_W){1'b0}}, CURVE_IN[k]});
  assign in_km1   = $signed({{(THR_W-SPD_W){1'b0}}, CURVE_IN[k - 1'b1]});
  assign in_first = $signed({{(THR_W-SPD_W){1'b0}}, CURVE_IN[0]});
  assign in_last  = $signed({{(THR_W-SPD_W){1'b0}}, CURVE_IN[CURVE_POINTS-1]});
  assign seg_dv   = thr - in_km1;
  assign seg_dy   = $signed({1'b0, CURVE_OUT[k]}) - $signed({1'b0, CURVE_OUT[k - 1'b1]});
  assign seg_span = in_k - in_km1;
  assign seg_prod = NUMS_W'(seg_dv) * NUMS_W'(seg_dy);
  assign curve_sum = q_s + $signed({{(NUMS_W-SPD_W){1'b0}}, CURVE_OUT[k - 1'b1]});

  // ---- ramp ----
  assign step_sum = {1'b0, last_speed} + {1'b0, cfg.ramp_step};
  assign rise     = (last_speed < goal) && (step_sum < {1'b0, goal});
  assign spd      = rise ? step_sum[SPD_W-1:0] : goal;

  // ---- status ----
  assign div_start = ctrl.op == OP_DIV_START;
  assign div_step  = ctrl.op == OP_DIV_STEP;

  always_comb begin
    stat.req_taken   = in_valid && in_ready;
    stat.bypass      = bypass;
    stat.div_more    = div_more;
    stat.clamp       = (thr <= in_first) || (thr >= in_last);
    stat.search_more = (k < K_W'(CURVE_POINTS - 1)) && (thr > in_k);
    stat.seg_done    = (thr == in_k) || (seg_span == '0);
    stat.out_busy    = out_valid && !out_ready;
  end

  rctc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .step    (div_step),
    .num_mag (num_mag),
    .den_mag (den_mag),
    .quo     (quo),
    .more    (div_more)
  );

  // Control state: result valid and stored speed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_speed <= '0;
    end else if (ctrl.op == OP_RAMP && !stat.out_busy) begin
      out_valid  <= 1'b1;
      last_speed <= spd;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_FETCH: begin
        if (in_valid) begin
          p <= pulse_width;
        end
      end
      OP_MAP: begin
        absent <= absent_now;
        num    <= map_prod;
        den    <= den_map;
        thr    <= THR_W'(cfg.idle_value);
      end
      OP_DIV_START: begin
        q_neg <= num[NUMS_W-1] ^ den[DENS_W-1];
      end
      OP_MAP_END: begin
        thr <= thr_map;
      end
      OP_CLAMP: begin
        k <= K_W'(1);
        if (thr <= in_first) begin
          goal <= CURVE_OUT[0];
        end else begin
          goal <= CURVE_OUT[CURVE_POINTS-1];
        end
      end
      OP_SEARCH: begin
        if (stat.search_more) begin
          k <= k + 1'b1;
        end
      end
      OP_SEG: begin
        goal <= CURVE_OUT[k];
        num  <= seg_prod;
        den  <= seg_span;
      end
      OP_CURVE_END: begin
        goal <= curve_sum[SPD_W-1:0];
      end
      OP_RAMP: begin
        if (!stat.out_busy) begin
          throttle      <= thr;
          goal_speed    <= goal;
          speed         <= spd;
          signal_absent <= absent;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/rc_throttle_curve_ramp.sv]
// ----------------------------------------------------------------------------
// rc_throttle_curve_ramp - RC throttle mapping, S-curve and speed ramp
// Top level: configuration registers, control sequencer and datapath.
// ----------------------------------------------------------------------------
// One request carries a measured pulse width and yields one result. The width
// is mapped linearly from [pulse_low, pulse_high] onto [out_min, out_max]
// (quotient truncated toward zero, saturated to 16 bits, deadband applied),
// or replaced by idle_value when the pulse is below absent_threshold or the
// pulse limits are equal. The throttle is shaped by a fixed 12-point S-curve
// and the resulting goal speed is ramped upward by at most ramp_step per
// request; drops take effect at once. The map and the curve interpolation
// each run 27 steps of a shared one-bit-per-cycle divider, the segment search
// walks the curve table one point per cycle, and the ramp step holds for as
// long as the previous result is still waiting in the output register. On the
// shortest path a taken request passes the map, clamp and ramp steps, and
// its result is registered at the ramp step.
// The next request is taken as soon as the program returns to its fetch step,
// even while the previous result still waits in the output register.
// Configuration writes are always accepted; write them only while no request
// is in flight.
// ----------------------------------------------------------------------------
module rc_throttle_curve_ramp (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rctc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rctc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rctc_pkg::PW_W-1:0]            pulse_width,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rctc_pkg::THR_W-1:0]    throttle,
  output logic [rctc_pkg::SPD_W-1:0]           goal_speed,
  output logic [rctc_pkg::SPD_W-1:0]           speed,
  output logic                                 signal_absent
);
  import rctc_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  // Register file never stalls a write
  assign cfg_ready = 1'b1;

  // Hold settings; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PULSE_LOW:        cfg.pulse_low        <= cfg_data[PW_W-1:0];
        REG_PULSE_HIGH:       cfg.pulse_high       <= cfg_data[PW_W-1:0];
        REG_OUT_MIN:          cfg.out_min          <= $signed(cfg_data[CV_W-1:0]);
        REG_OUT_MAX:          cfg.out_max          <= $signed(cfg_data[CV_W-1:0]);
        REG_ABSENT_THRESHOLD: cfg.absent_threshold <= cfg_data[PW_W-1:0];
        REG_IDLE_VALUE:       cfg.idle_value       <= $signed(cfg_data[CV_W-1:0]);
        REG_DEADBAND:         cfg.deadband         <= cfg_data[DB_W-1:0];
        REG_RAMP_STEP:        cfg.ramp_step        <= cfg_data[SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step counter and control store
  rctc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Datapath driven by the current control word
  rctc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .stat          (stat),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pulse_width   (pulse_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .throttle      (throttle),
    .goal_speed    (goal_speed),
    .speed         (speed),
    .signal_absent (signal_absent)
  );

`ifndef SYNTHESIS
  // After taking a request the program leaves its fetch step
  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  // The ramp never overshoots the goal
  a_speed_not_above_goal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed <= goal_speed)
    else $error("speed above goal speed");

  // Absent signal always reports the idle throttle
  a_absent_gives_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && signal_absent |-> throttle == THR_W'(cfg.idle_value))
    else $error("absent signal without idle throttle");
`endif

endmodule

[sim/tb_rc_throttle_curve_ramp.sv]
// ----------------------------------------------------------------------------
// tb_rc_throttle_curve_ramp - self-checking bench for the throttle curve ramp
// Sends pulse widths through a valid/ready request channel and rewrites the
// settings between phases. A built-in predictor recomputes the mapping, the
// S-curve and the speed ramp, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_rc_throttle_curve_ramp;
  import rctc_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 100;
  localparam int REG_COUNT    = 8;
  localparam int PW_MAX       = 2**PW_W - 1;

  // percent of cycles in which a side holds off
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 11;
  localparam int IDLE_HEAVY = 82;

  typedef logic [CFG_IDX_W-1:0] reg_index_t;

  typedef struct packed {
    logic signed [THR_W-1:0] throttle;
    logic [SPD_W-1:0]        goal_speed;
    logic [SPD_W-1:0]        speed;
    logic                    signal_absent;
  } drive_result_t;

  typedef enum logic {PEND_PULSE, PEND_WRITE} pend_kind_t;

  typedef struct packed {
    pend_kind_t              kind;
    logic [PW_W-1:0]         pulse;
    reg_index_t              idx;
    logic [CFG_DATA_W-1:0]   data;
  } pending_req_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  reg_index_t                 cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [PW_W-1:0]            pulse_width = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [THR_W-1:0]    throttle;
  logic [SPD_W-1:0]           goal_speed;
  logic [SPD_W-1:0]           speed;
  logic                       signal_absent;

  pending_req_t   pending_reqs[$];    // requests and writes not yet presented
  drive_result_t  expected_drive[$];  // predicted results, oldest first

  cfg_t            model_cfg = CFG_RESET;   // settings as the block holds them
  cfg_t            plan_cfg = CFG_RESET;    // settings as the stimulus will leave them
  logic [SPD_W-1:0] last_speed_model = '0;

  int send_idle_pct = IDLE_NONE;
  int recv_stall_pct = IDLE_NONE;
  int error_count = 0;
  int stall_cycles = 0;

  rc_throttle_curve_ramp dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pulse_width   (pulse_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .throttle      (throttle),
    .goal_speed    (goal_speed),
    .speed         (speed),
    .signal_absent (signal_absent)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Settings after one register write; data bits above the field are dropped
  // and writes to unused indexes leave everything as it was.
  function automatic cfg_t with_write(cfg_t c, reg_index_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_t r;
    r = c;
    case (idx)
      REG_PULSE_LOW:        r.pulse_low = d[PW_W-1:0];
      REG_PULSE_HIGH:       r.pulse_high = d[PW_W-1:0];
      REG_OUT_MIN:          r.out_min = d[CV_W-1:0];
      REG_OUT_MAX:          r.out_max = d[CV_W-1:0];
      REG_ABSENT_THRESHOLD: r.absent_threshold = d[PW_W-1:0];
      REG_IDLE_VALUE:       r.idle_value = d[CV_W-1:0];
      REG_DEADBAND:         r.deadband = d[DB_W-1:0];
      REG_RAMP_STEP:        r.ramp_step = d[SPD_W-1:0];
      default: ;
    endcase
    return r;
  endfunction

  // Throttle, goal and ramped speed for one pulse width, given the settings
  // and the speed left by the previous request.
  function automatic drive_result_t predict_drive(cfg_t c, logic [SPD_W-1:0] prev,
                                                  logic [PW_W-1:0] pw);
    drive_result_t r;
    longint p, lo, hi, lim, m;
    int thr, goal, seg, span;
    p = pw;
    lo = c.pulse_low;
    hi = c.pulse_high;
    lim = c.deadband;
    r.signal_absent = 1'b0;
    if (p < longint'(c.absent_threshold)) begin
      r.signal_absent = 1'b1;
      thr = c.idle_value;
    end else if (hi == lo) begin
      thr = c.idle_value;
    end else begin
      // signed division truncates toward zero; reversed limits give a falling line
      m = (p - lo) * (longint'(c.out_max) - longint'(c.out_min)) / (hi - lo)
          + longint'(c.out_min);
      if (m > THR_MAX) m = THR_MAX;
      if (m < THR_MIN) m = THR_MIN;
      if (m < lim && m > -lim) m = 0;
      thr = int'(m);
    end

    // clamp outside the table, otherwise interpolate inside the segment
    if (thr <= int'(CURVE_IN[0])) begin
      goal = CURVE_OUT[0];
    end else if (thr >= int'(CURVE_IN[CURVE_POINTS-1])) begin
      goal = CURVE_OUT[CURVE_POINTS-1];
    end else begin
      seg = 1;
      while (seg < CURVE_POINTS - 1 && thr > int'(CURVE_IN[seg])) seg++;
      span = int'(CURVE_IN[seg]) - int'(CURVE_IN[seg-1]);
      if (thr == int'(CURVE_IN[seg]) || span == 0) begin
        goal = CURVE_OUT[seg];
      end else begin
        goal = (thr - int'(CURVE_IN[seg-1])) * (int'(CURVE_OUT[seg]) - int'(CURVE_OUT[seg-1]))
               / span + int'(CURVE_OUT[seg-1]);
      end
    end

    // rise by at most one step, drop at once
    if (int'(prev) < goal && int'(prev) + int'(c.ramp_step) < goal) begin
      r.speed = prev + c.ramp_step;
    end else begin
      r.speed = goal[SPD_W-1:0];
    end
    r.throttle = thr[THR_W-1:0];
    r.goal_speed = goal[SPD_W-1:0];
    return r;
  endfunction

  function automatic logic [PW_W-1:0] clip_pw(int v);
    if (v < 0) return '0;
    if (v > PW_MAX) return PW_W'(PW_MAX);
    return v[PW_W-1:0];
  endfunction

  // Mostly widths in and around the mapped span, some near the absent
  // threshold, some anywhere, some on the hard edges.
  function automatic logic [PW_W-1:0] random_pulse(cfg_t c);
    int lo, hi, pick;
    logic [PW_W-1:0] pw;
    lo = (c.pulse_low < c.pulse_high) ? int'(c.pulse_low) : int'(c.pulse_high);
    hi = (c.pulse_low < c.pulse_high) ? int'(c.pulse_high) : int'(c.pulse_low);
    pick = $urandom_range(99);
    if (pick < 55) begin
      pw = clip_pw(lo - 20 + int'($urandom_range(hi - lo + 40)));
    end else if (pick < 70) begin
      pw = clip_pw(int'(c.absent_threshold) - 3 + int'($urandom_range(6)));
    end else if (pick < 88) begin
      pw = PW_W'($urandom());
    end else begin
      case ($urandom_range(3))
        0:       pw = '0;
        1:       pw = PW_W'(PW_MAX);
        2:       pw = clip_pw(lo);
        default: pw = clip_pw(hi);
      endcase
    end
    return pw;
  endfunction

  task automatic push_write(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    pending_req_t req;
    req = '{kind: PEND_WRITE, pulse: '0, idx: idx, data: data};
    pending_reqs.push_back(req);
    plan_cfg = with_write(plan_cfg, idx, data);
  endtask

  task automatic push_pulse(logic [PW_W-1:0] pw);
    pending_req_t req;
    req = '{kind: PEND_PULSE, pulse: pw, idx: '0, data: '0};
    pending_reqs.push_back(req);
  endtask

  task automatic push_random(int count);
    repeat (count) push_pulse(random_pulse(plan_cfg));
  endtask

  // Fully random settings, upper data bits included, plus a stray write
  // to an index past the register file.
  task automatic push_random_settings();
    for (int i = 0; i < REG_COUNT; i++) push_write(reg_index_t'(i), CFG_DATA_W'($urandom()));
    push_write(reg_index_t'($urandom_range(2**CFG_IDX_W - 1, REG_COUNT)),
               CFG_DATA_W'($urandom()));
  endtask

  // Hold until every request is in and every result is out, then switch
  // the idle pattern away from the clock edge.
  task automatic start_phase(int sender_idle, int receiver_stall);
    while (pending_reqs.size() != 0 || expected_drive.size() != 0 || in_valid || cfg_valid)
      @(posedge clk);
    @(negedge clk);
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
  endtask

  // Request side: present the head of the pending queue, keep valid and
  // payload steady until taken, and predict each request as it is accepted.
  // A register write goes out only once nothing is in flight.
  always @(posedge clk) begin : drive_requests
    logic in_hold;
    logic cfg_hold;
    logic in_next;
    logic cfg_next;
    pending_req_t head;
    drive_result_t due;
    if (rst) begin
      in_valid <= 1'b0;
      pulse_width <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      model_cfg = CFG_RESET;
      last_speed_model = '0;
    end else begin
      in_hold = in_valid && !in_ready;
      cfg_hold = cfg_valid && !cfg_ready;
      in_next = in_hold;
      cfg_next = cfg_hold;
      if (in_valid && in_ready) begin
        due = predict_drive(model_cfg, last_speed_model, pulse_width);
        last_speed_model = due.speed;
        expected_drive.push_back(due);
      end
      if (cfg_valid && cfg_ready) model_cfg = with_write(model_cfg, cfg_index, cfg_data);
      if (!in_hold && !cfg_hold && pending_reqs.size() != 0) begin
        if (pending_reqs[0].kind == PEND_WRITE) begin
          if (expected_drive.size() == 0) begin
            head = pending_reqs.pop_front();
            cfg_index <= head.idx;
            cfg_data <= head.data;
            cfg_next = 1'b1;
          end
        end else if ($urandom_range(99) >= send_idle_pct) begin
          head = pending_reqs.pop_front();
          pulse_width <= head.pulse;
          in_next = 1'b1;
        end
      end
      in_valid <= in_next;
      cfg_valid <= cfg_next;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side: stall at random, compare every accepted result with the
  // oldest prediction.
  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $error("result with no request waiting: throttle %0d speed %0d", throttle, speed);
          error_count++;
        end else begin
          want = expected_drive.pop_front();
          check_field("throttle", want.throttle, throttle);
          check_field("goal_speed", want.goal_speed, goal_speed);
          check_field("speed", want.speed, speed);
          check_field("signal_absent", want.signal_absent, signal_absent);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up when no channel has moved for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("rc_throttle_curve_ramp verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: absent threshold edges, pulse limits, deadband edges
    // on both sides of zero, the top of the width range.
    start_phase(IDLE_NONE, IDLE_NONE);
    push_pulse(0);
    push_pulse(99);
    push_pulse(100);
    push_pulse(874);
    push_pulse(875);
    push_pulse(1483);
    push_pulse(1486);
    push_pulse(1532);
    push_pulse(1533);
    push_pulse(2140);
    push_pulse(2141);
    push_pulse(PW_W'(PW_MAX));
    push_random(80);

    // Throttle equals width minus 1024: walk the curve points, the spaces
    // between them, negatives and past the last point. Full ramp step.
    start_phase(IDLE_NONE, IDLE_HEAVY);
    push_write(REG_PULSE_LOW, 0);
    push_write(REG_PULSE_HIGH, 2047);
    push_write(REG_OUT_MIN, -1024);
    push_write(REG_OUT_MAX, 1023);
    push_write(REG_ABSENT_THRESHOLD, 0);
    push_write(REG_IDLE_VALUE, 0);
    push_write(REG_DEADBAND, 0);
    push_write(REG_RAMP_STEP, 255);
    push_write(reg_index_t'($urandom_range(2**CFG_IDX_W - 1, REG_COUNT)),
               CFG_DATA_W'($urandom()));
    push_pulse(0);
    push_pulse(1023);
    push_pulse(1024);
    push_pulse(1024 + 48);
    push_pulse(1024 + 60);
    push_pulse(1024 + 69);
    push_pulse(1024 + 254);
    push_pulse(1024 + 255);
    push_pulse(1024 + 256);
    push_random(100);

    // Steepest line: saturation at the top end, widest deadband, slowest rising ramp.
    start_phase(IDLE_HEAVY, IDLE_NONE);
    push_write(REG_PULSE_HIGH, 1);
    push_write(REG_DEADBAND, 1023);
    push_write(REG_RAMP_STEP, 1);
    push_random(100);

    // Reversed limits give a falling line; zero ramp step never rises.
    start_phase(IDLE_LIGHT, IDLE_LIGHT);
    push_write(REG_PULSE_LOW, 2000);
    push_write(REG_PULSE_HIGH, 1000);
    push_write(REG_OUT_MIN, -300);
    push_write(REG_OUT_MAX, 300);
    push_write(REG_ABSENT_THRESHOLD, 500);
    push_write(REG_IDLE_VALUE, -1024);
    push_write(REG_DEADBAND, 50);
    push_write(REG_RAMP_STEP, 0);
    push_random(100);

    // Equal pulse limits fall back to the idle throttle; set the upper
    // data bits, which the registers must drop.
    start_phase(IDLE_NONE, IDLE_NONE);
    push_write(REG_PULSE_LOW, {1'b1, 15'd1500});
    push_write(REG_PULSE_HIGH, 1500);
    push_write(REG_IDLE_VALUE, {5'b10101, 11'd200});
    push_write(REG_ABSENT_THRESHOLD, 1000);
    push_write(REG_RAMP_STEP, {8'hA5, 8'd7});
    push_random(60);

    start_phase(IDLE_NONE, IDLE_HEAVY);
    push_random_settings();
    push_random(100);

    // Highest threshold: only the top width counts as a signal.
    start_phase(IDLE_LIGHT, IDLE_LIGHT);
    push_write(REG_PULSE_LOW, 875);
    push_write(REG_PULSE_HIGH, 2140);
    push_write(REG_OUT_MIN, -255);
    push_write(REG_OUT_MAX, 255);
    push_write(REG_ABSENT_THRESHOLD, CFG_DATA_W'(PW_MAX));
    push_write(REG_IDLE_VALUE, 1023);
    push_write(REG_DEADBAND, 10);
    push_write(REG_RAMP_STEP, 15);
    push_random(60);

    start_phase(IDLE_HEAVY, IDLE_NONE);
    push_random_settings();
    push_random(100);

    start_phase(IDLE_NONE, IDLE_NONE);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("rc_throttle_curve_ramp verification clean");
    end else begin
      $display("rc_throttle_curve_ramp verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/rctc_pkg.sv
src/rctc_div.sv
src/rctc_seq.sv
src/rctc_datapath.sv
src/rc_throttle_curve_ramp.sv
sim/tb_rc_throttle_curve_ramp.sv
